FILE: hw/rtl/sdd_pkg.sv
package sdd_pkg;

	// Register file of the ducker, one field per configuration register.
	typedef struct packed {
		logic signed [14:0] threshold_db;
		logic signed [13:0] amount_db;
		logic [12:0]        knee_db;
		logic [15:0]        attack_coeff;
		logic [15:0]        release_coeff;
		logic [16:0]        hold_samples;
		logic               sidechain_enable;
	} sdd_cfg_t;

	localparam sdd_cfg_t CFG_RESET = '{
		threshold_db:     -15'sd5120,
		amount_db:        -14'sd3072,
		knee_db:          13'd1536,
		attack_coeff:     16'd65500,
		release_coeff:    16'd65530,
		hold_samples:     17'd0,
		sidechain_enable: 1'b0
	};

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 3'd0,
		REG_AMOUNT    = 3'd1,
		REG_KNEE      = 3'd2,
		REG_ATTACK    = 3'd3,
		REG_RELEASE   = 3'd4,
		REG_HOLD      = 3'd5,
		REG_SIDECHAIN = 3'd6
	} reg_idx_t;

	// Detector floor, -144 dB in 1/256 dB, as a magnitude.
	localparam logic [15:0] LEVEL_FLOOR_MAG = 16'd36864;
	// 20*log10(2)*256 in Q16.
	localparam logic [26:0] DB_PER_LOG2_Q16 = 27'd101008905;
	// log2(10)/20/256 in Q16 scaled by 2^16.
	localparam logic [21:0] LOG2_PER_DB_Q16 = 22'd2786636;

endpackage

FILE: hw/rtl/sdd_front.sv
module sdd_front #(
	parameter int SB = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            sidechain_enable,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [4*SB-1:0] in_data,
	output logic            push_valid,
	input  logic            push_ready,
	output logic [3*SB-1:0] push_data
);

	logic [SB-1:0] al, ar, sl, sr, dl, dr, ml, mr, mx;
	logic          valid_s1;
	logic [3*SB-1:0] data_s1;

	assign al = in_data[SB-1:0];
	assign ar = in_data[2*SB-1:SB];
	assign sl = in_data[3*SB-1:2*SB];
	assign sr = in_data[4*SB-1:3*SB];

	// detector pick and peak magnitude; full-scale negative maps to 2^(SB-1)
	assign dl = sidechain_enable ? sl : al;
	assign dr = sidechain_enable ? sr : ar;
	assign ml = dl[SB-1] ? (~dl + 1'b1) : dl;
	assign mr = dr[SB-1] ? (~dr + 1'b1) : dr;
	assign mx = (ml > mr) ? ml : mr;

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= {mx, ar, al};
		end
	end

endmodule

FILE: hw/rtl/sdd_queue.sv
module sdd_queue #(
	parameter int WIDTH = 72
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;
	logic             wr_en, rd_en;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign wr_en    = wr_valid && wr_ready;
	assign rd_en    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) wr_ptr_q <= !wr_ptr_q;
			if (rd_en) rd_ptr_q <= !rd_ptr_q;
			if (wr_en && !rd_en) count_q <= count_q + 2'd1;
			else if (rd_en && !wr_en) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

FILE: hw/rtl/sdd_back.sv
module sdd_back import sdd_pkg::*; #(
	parameter int SB = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  sdd_cfg_t        cfg,
	input  logic            item_valid,
	output logic            item_ready,
	input  logic [3*SB-1:0] item_data,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [SB-1:0]   out_left,
	output logic [SB-1:0]   out_right,
	output logic [13:0]     gain_db
);

	localparam int W = SB + 33;
	localparam logic signed [W-1:0] SAT_HI = W'((longint'(1) <<< (SB - 1)) - 1);
	localparam logic signed [W-1:0] SAT_LO = -SAT_HI - W'(1);
	localparam logic [20:0] FULL_LG = 21'((SB - 1) * 65536);

	typedef enum logic [3:0] {
		S_IDLE, S_NORM, S_LOG, S_DB, S_TGT, S_DIV, S_ENV, S_EXP,
		S_SQI, S_SQRT, S_MUL, S_OUT
	} state_t;

	state_t state_q;

	logic signed [SB-1:0] al_q, ar_q;
	logic [SB-1:0]        mag_q;
	logic [4:0]           p_q, cnt_q;
	logic [31:0]          x_q;
	logic [15:0]          frac_q;
	logic signed [16:0]   level_q;
	logic [13:0]          amag_q, quo_q;
	logic [27:0]          rem_q, dsh_q;
	logic signed [14:0]   tgt_q;
	logic signed [24:0]   env_q;
	logic [16:0]          hold_q;
	logic signed [13:0]   g_q;
	logic [19:0]          ep_q;
	logic [3:0]           step_q;
	logic [30:0]          y_q, root_q;
	logic [61:0]          rad_q;
	logic [32:0]          rmd_q;
	logic [SB-1:0]        res_l_q, res_r_q;
	logic                 out_valid_q;
	logic [SB-1:0]        out_left_q, out_right_q;
	logic [13:0]          gain_q;

	// normalize
	logic [4:0]  p_c;
	logic [31:0] x_c;
	// log2 squaring
	logic [63:0] sq_c;
	logic [32:0] sqs_c;
	// dB conversion
	logic [20:0] neg_c;
	logic [47:0] dbp_c;
	logic [15:0] dbm_c;
	logic signed [16:0] lvl_c;
	// knee
	logic signed [19:0] num_c;
	logic [13:0] twok_c, amag_c;
	logic [27:0] dvd_c;
	logic        hard_c;
	// envelope
	logic signed [26:0] t27_c, e27_c, at_c, ae_c, diff_c;
	logic        engage_c;
	logic [16:0] omc_c;
	logic signed [44:0] eprod_c, esum_c;
	logic signed [24:0] env_n_c;
	// gain exponent
	logic signed [26:0] er_c;
	logic signed [13:0] g_c;
	logic signed [36:0] gm_c;
	logic signed [19:0] e_c;
	// square root
	logic [31:0] yy_c;
	logic [34:0] rn_c, trial_c;
	logic        sq_ge_c;
	logic [30:0] root_n_c;
	// output multiply
	logic [5:0]  shamt_c;
	logic signed [W-1:0] pl_c, pr_c, rb_c, rl_c, rr_c;
	logic [SB-1:0] sat_l_c, sat_r_c;

	always_comb begin
		p_c = 5'd0;
		for (int i = 0; i < SB; i++) begin
			if (mag_q[i]) p_c = 5'(i);
		end
	end
	assign x_c = 32'(mag_q) << (5'd31 - p_c);

	assign sq_c  = 64'(x_q) * 64'(x_q);
	assign sqs_c = sq_c[63:31];

	assign neg_c = FULL_LG - {p_q, frac_q};
	assign dbp_c = 48'(neg_c) * 48'(DB_PER_LOG2_Q16);
	assign dbm_c = 16'((dbp_c + 48'h0000_8000_0000) >> 32);
	assign lvl_c = (dbm_c > LEVEL_FLOOR_MAG) ? -17'sd36864 : -$signed({1'b0, dbm_c});

	assign num_c  = (20'(level_q) - 20'(cfg.threshold_db)) * 20'sd2
		+ $signed({7'd0, cfg.knee_db});
	assign twok_c = {cfg.knee_db, 1'b0};
	assign amag_c = cfg.amount_db[13] ? (~cfg.amount_db + 1'b1) : cfg.amount_db;
	assign dvd_c  = 28'(amag_c) * 28'(num_c[13:0]) + 28'(cfg.knee_db);
	assign hard_c = level_q > cfg.threshold_db;

	assign t27_c    = {tgt_q[14], tgt_q, 11'd0};
	assign e27_c    = {{2{env_q[24]}}, env_q};
	assign at_c     = t27_c[26] ? -t27_c : t27_c;
	assign ae_c     = e27_c[26] ? -e27_c : e27_c;
	assign engage_c = at_c > ae_c;
	assign omc_c    = 17'h10000 - 17'(engage_c ? cfg.attack_coeff : cfg.release_coeff);
	assign diff_c   = t27_c - e27_c;
	assign eprod_c  = 45'($signed({1'b0, omc_c})) * 45'(diff_c);
	assign esum_c   = eprod_c + 45'sd32768;
	assign env_n_c  = 25'(e27_c + 27'(esum_c >>> 16));

	// gain_db = round(env / 2048); exponent e = round(gain_db * k / 2^16)
	assign er_c = e27_c + 27'sd1024;
	assign g_c  = er_c[24:11];
	assign gm_c = 37'(g_c) * 37'($signed({1'b0, LOG2_PER_DB_Q16}));
	assign e_c  = 20'((gm_c + 37'sd32768) >>> 16);

	assign yy_c     = ep_q[step_q] ? {y_q, 1'b0} : {1'b0, y_q};
	assign rn_c     = {rmd_q, rad_q[61:60]};
	assign trial_c  = {2'd0, root_q, 2'b01};
	assign sq_ge_c  = rn_c >= trial_c;
	assign root_n_c = {root_q[29:0], sq_ge_c};

	assign shamt_c = 6'd38 - {2'd0, ep_q[19:16]};
	assign pl_c    = W'(al_q) * W'($signed({1'b0, y_q}));
	assign pr_c    = W'(ar_q) * W'($signed({1'b0, y_q}));
	assign rb_c    = W'(1) <<< (shamt_c - 6'd1);
	assign rl_c    = (pl_c + rb_c) >>> shamt_c;
	assign rr_c    = (pr_c + rb_c) >>> shamt_c;
	assign sat_l_c = (rl_c > SAT_HI) ? SAT_HI[SB-1:0] :
		(rl_c < SAT_LO) ? SAT_LO[SB-1:0] : rl_c[SB-1:0];
	assign sat_r_c = (rr_c > SAT_HI) ? SAT_HI[SB-1:0] :
		(rr_c < SAT_LO) ? SAT_LO[SB-1:0] : rr_c[SB-1:0];

	assign item_ready = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign out_left   = out_left_q;
	assign out_right  = out_right_q;
	assign gain_db    = gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= 5'd0;
			step_q      <= 4'd0;
			env_q       <= '0;
			hold_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						al_q    <= item_data[SB-1:0];
						ar_q    <= item_data[2*SB-1:SB];
						mag_q   <= item_data[3*SB-1:2*SB];
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					p_q    <= p_c;
					x_q    <= x_c;
					frac_q <= 16'd0;
					cnt_q  <= 5'd15;
					if (mag_q == '0) begin
						level_q <= -17'sd36864;
						state_q <= S_TGT;
					end else begin
						state_q <= S_LOG;
					end
				end
				S_LOG: begin
					if (sqs_c[32]) begin
						x_q    <= sqs_c[32:1];
						frac_q <= {frac_q[14:0], 1'b1};
					end else begin
						x_q    <= sqs_c[31:0];
						frac_q <= {frac_q[14:0], 1'b0};
					end
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) state_q <= S_DB;
				end
				S_DB: begin
					level_q <= lvl_c;
					state_q <= S_TGT;
				end
				S_TGT: begin
					amag_q  <= amag_c;
					state_q <= S_ENV;
					if (cfg.knee_db == '0) begin
						tgt_q <= hard_c ? 15'(cfg.amount_db) : 15'sd0;
					end else if (num_c <= 20'sd0) begin
						tgt_q <= 15'sd0;
					end else if (num_c >= $signed({6'd0, twok_c})) begin
						tgt_q <= 15'(cfg.amount_db);
					end else begin
						rem_q   <= dvd_c;
						dsh_q   <= 28'(twok_c) << 13;
						quo_q   <= 14'd0;
						cnt_q   <= 5'd13;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (rem_q >= dsh_q) rem_q <= rem_q - dsh_q;
					quo_q <= {quo_q[12:0], rem_q >= dsh_q};
					dsh_q <= dsh_q >> 1;
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						// the last quotient bit lands this cycle
						state_q <= S_ENV;
					end
				end
				S_ENV: begin
					if (engage_c) begin
						env_q  <= env_n_c;
						hold_q <= cfg.hold_samples;
					end else if (hold_q != '0) begin
						hold_q <= hold_q - 17'd1;
					end else begin
						env_q <= env_n_c;
					end
					state_q <= S_EXP;
				end
				S_EXP: begin
					g_q     <= g_c;
					ep_q    <= {~e_c[19], e_c[18:0]};
					y_q     <= 31'h4000_0000;
					step_q  <= 4'd0;
					state_q <= S_SQI;
				end
				S_SQI: begin
					rad_q   <= {yy_c, 30'd0};
					root_q  <= 31'd0;
					rmd_q   <= 33'd0;
					cnt_q   <= 5'd30;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					rmd_q  <= sq_ge_c ? 33'(rn_c - trial_c) : 33'(rn_c);
					root_q <= root_n_c;
					rad_q  <= {rad_q[59:0], 2'b00};
					cnt_q  <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						y_q    <= root_n_c;
						step_q <= step_q + 4'd1;
						state_q <= (step_q == 4'd15) ? S_MUL : S_SQI;
					end
				end
				S_MUL: begin
					res_l_q <= sat_l_c;
					res_r_q <= sat_r_c;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_left_q  <= res_l_q;
						out_right_q <= res_r_q;
						gain_q      <= g_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_DIV && cnt_q == 5'd0) begin
				tgt_q <= cfg.amount_db[13] ? -$signed({1'b0, {quo_q[12:0], rem_q >= dsh_q}})
					: $signed({1'b0, {quo_q[12:0], rem_q >= dsh_q}});
			end
		end
	end

	a_hold_only_in_env: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_ENV) |=> $stable(hold_q))
		else $error("hold counter moved outside the envelope step");

	a_env_frozen_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ENV && !engage_c && hold_q != '0) |=> $stable(env_q))
		else $error("envelope moved while hold count was running");

	a_quotient_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && cnt_q == 5'd0) |=> (quo_q <= amag_q))
		else $error("knee quotient exceeds full duck amount");

endmodule

FILE: hw/rtl/stereo_sidechain_ducker_unit.sv
// Stereo sidechain ducker: soft-knee (hard when the knee is zero) duck with attack, hold and release.
//
// s_axis: one stereo audio frame plus one stereo sidechain frame per
//   transaction. m_axis: the ducked stereo frame and the envelope gain in
//   1/256 dB. cfg_we/cfg_index/cfg_data write one register per clock; write
//   only while no frame is in flight.
// Flow: a front stage picks the detector pair and takes its peak magnitude,
//   a two-entry queue decouples it from the back-end sequencer, which runs
//   log2 by 16 squarings, dB scaling, the knee divide (14 steps, soft knee
//   only), the envelope step, then 2^frac as 16 square roots, and the final
//   two multiplies.
// The back end holds one frame at a time and takes no new frame until the
//   last has gone to the output register; its bit-serial square-root unit
//   does the longest part of the work.
// The front and the queue keep taking frames while the back end works,
//   until both are full, and a finished result waits in the output register
//   while the next frame is already in progress; a stalled m_axis_tready
//   only holds the back end once it has its next result ready.
// Reset (arst_n low): registers return to their defaults, envelope and hold
//   count go to zero, queue and output register empty.
module stereo_sidechain_ducker_unit import sdd_pkg::*; #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// audio_left, audio_right, side_left, side_right (lowest bits first)
	input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// out_left, out_right, gain_db (lowest bits first), zero padded
	output logic [((2*SAMPLE_BITS+14+7)/8)*8-1:0] m_axis_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SB    = SAMPLE_BITS;
	localparam int OUT_W = ((2*SB+14+7)/8)*8;

	sdd_cfg_t        cfg_q;
	logic            push_valid, push_ready, pop_valid, pop_ready;
	logic [3*SB-1:0] push_data, pop_data;
	logic [SB-1:0]   out_left, out_right;
	logic [13:0]     gain_db;

	// register file; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD: cfg_q.threshold_db     <= cfg_data[14:0];
				REG_AMOUNT:    cfg_q.amount_db        <= cfg_data[13:0];
				REG_KNEE:      cfg_q.knee_db          <= cfg_data[12:0];
				REG_ATTACK:    cfg_q.attack_coeff     <= cfg_data[15:0];
				REG_RELEASE:   cfg_q.release_coeff    <= cfg_data[15:0];
				REG_HOLD:      cfg_q.hold_samples     <= cfg_data[16:0];
				REG_SIDECHAIN: cfg_q.sidechain_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// front: detector select and peak magnitude
	sdd_front #(.SB(SB)) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.sidechain_enable (cfg_q.sidechain_enable),
		.in_valid         (s_axis_tvalid),
		.in_ready         (s_axis_tready),
		.in_data          (s_axis_tdata[4*SB-1:0]),
		.push_valid       (push_valid),
		.push_ready       (push_ready),
		.push_data        (push_data)
	);

	sdd_queue #(.WIDTH(3*SB)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_data  (push_data),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready),
		.rd_data  (pop_data)
	);

	// back: level, knee, envelope, gain
	sdd_back #(.SB(SB)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (pop_valid),
		.item_ready (pop_ready),
		.item_data  (pop_data),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_left   (out_left),
		.out_right  (out_right),
		.gain_db    (gain_db)
	);

	assign m_axis_tdata = OUT_W'({gain_db, out_right, out_left});

endmodule
